/* design/rth_pkg.sv */
`timescale 1ns / 1ps

package rth_pkg;

  // default fraction width of the outputs
  localparam int FRAC_BITS_DEF = 16;

  // width of a divisor and of a partial remainder in every divider lane
  localparam int DIV_W = 12;

  // divider lanes
  localparam int LANES    = 3;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;
  localparam int LANE_LIT = 2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] hue_out;
    logic [15:0] sat_out;
    logic [15:0] light_out;
    logic [7:0]  alpha_out;
  } pix_out_t;

  // remainders or divisors of all lanes
  typedef logic [LANES-1:0][DIV_W-1:0] lane_word_t;

  // side info that travels with a word down the chain
  typedef struct packed {
    logic       vld;
    logic       gray;
    logic [7:0] alpha;
  } side_t;

endpackage

/* design/rth_prep.sv */
`timescale 1ns / 1ps

module rth_prep #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF,
  parameter int QB        = FRAC_BITS + 1
) (
  input  rth_pkg::pix_in_t                    pix,
  output rth_pkg::lane_word_t                 rem,
  output rth_pkg::lane_word_t                 den,
  output logic [rth_pkg::LANES-1:0][QB-1:0]   qs,
  output logic                                gray
);
  import rth_pkg::*;

  localparam int NW = QB + DIV_W;

  logic [7:0]    r, g, b, mx, mn, d;
  logic [8:0]    s, q;
  logic [11:0]   n;
  logic [NW-1:0] num_hue, num_sat, num_lit;
  logic [NW-1:0] d_w, s_w, q_w, n_w;

  // max, min, span and sum
  always_comb begin
    r  = pix.red_in;
    g  = pix.green_in;
    b  = pix.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    s  = {1'b0, mx} + {1'b0, mn};
    q  = (s < 9'd255) ? s : (9'd510 - s);
  end

  // hue sector offset, red wins ties, then green
  always_comb begin
    if (r == mx) begin
      if (g >= b) n = {4'd0, g - b};
      else n = 12'(6 * d) - {4'd0, b} + {4'd0, g};
    end else if (g == mx) begin
      n = {3'd0, d, 1'b0} + {4'd0, b} - {4'd0, r};
    end else begin
      n = {2'd0, d, 2'd0} + {4'd0, r} - {4'd0, g};
    end
  end

  // rounded quotients: numerator 2*num + den over 2*den
  always_comb begin
    d_w     = NW'(d);
    s_w     = NW'(s);
    q_w     = NW'(q);
    n_w     = NW'(n);
    num_hue = (n_w << (FRAC_BITS + 1)) + NW'(6 * d_w);
    num_sat = (d_w << (FRAC_BITS + 1)) - (d_w << 1) + q_w;
    num_lit = (s_w << (FRAC_BITS + 1)) - (s_w << 1) + NW'(510);
  end

  assign rem[LANE_HUE] = num_hue[NW-1:QB];
  assign rem[LANE_SAT] = num_sat[NW-1:QB];
  assign rem[LANE_LIT] = num_lit[NW-1:QB];
  assign qs[LANE_HUE]  = num_hue[QB-1:0];
  assign qs[LANE_SAT]  = num_sat[QB-1:0];
  assign qs[LANE_LIT]  = num_lit[QB-1:0];
  assign den[LANE_HUE] = DIV_W'(12 * d_w);
  assign den[LANE_SAT] = {2'd0, q, 1'b0};
  assign den[LANE_LIT] = DIV_W'(1020);
  assign gray          = (d == 8'd0);

endmodule

/* design/rth_cell.sv */
`timescale 1ns / 1ps

module rth_cell #(
  parameter int QB = rth_pkg::FRAC_BITS_DEF + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  rth_pkg::side_t                      side_in,
  input  rth_pkg::lane_word_t                 rem_in,
  input  rth_pkg::lane_word_t                 den_in,
  input  logic [rth_pkg::LANES-1:0][QB-1:0]   qs_in,
  output rth_pkg::side_t                      side,
  output rth_pkg::lane_word_t                 rem,
  output rth_pkg::lane_word_t                 den,
  output logic [rth_pkg::LANES-1:0][QB-1:0]   qs
);
  import rth_pkg::*;

  lane_word_t                 rem_next;
  logic [LANES-1:0][QB-1:0]   qs_next;
  logic [LANES-1:0][DIV_W:0]  trial;
  logic [LANES-1:0]           ge;

  // one restoring step per lane: bring in a numerator bit, try subtract
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i]    = {rem_in[i], qs_in[i][QB-1]};
      ge[i]       = trial[i] >= {1'b0, den_in[i]};
      rem_next[i] = ge[i] ? DIV_W'(trial[i] - {1'b0, den_in[i]}) : trial[i][DIV_W-1:0];
      qs_next[i]  = {qs_in[i][QB-2:0], ge[i]};
    end
  end

  // valid and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      side.vld <= 1'b0;
    end else if (en) begin
      side.vld <= side_in.vld;
    end
    if (en) begin
      side.gray  <= side_in.gray;
      side.alpha <= side_in.alpha;
      rem        <= rem_next;
      den        <= den_in;
      qs         <= qs_next;
    end
  end

endmodule

/* design/rgb_to_hsl_pixel.sv */
// Throughput: one word per cycle while the result is not stalled; one operand stage,
// then a chain of FRAC_BITS + 1 divider cells, each retiring one quotient bit for hue,
// saturation and lightness.
// The whole chain advances when the result register is empty or being taken.
// Reset (rst, synchronous, active high) clears every stage valid; data is not cleared.
`timescale 1ns / 1ps

module rgb_to_hsl_pixel #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  rth_pkg::pix_in_t  pix,
  output logic              hsl_valid,
  input  logic              hsl_ready,
  output rth_pkg::pix_out_t hsl
);
  import rth_pkg::*;

  localparam int QB = FRAC_BITS + 1;

  logic                                 adv;
  lane_word_t                           p_rem, p_den;
  logic [LANES-1:0][QB-1:0]             p_qs;
  logic                                 p_gray;
  side_t                                op_side;
  lane_word_t                           op_rem, op_den;
  logic [LANES-1:0][QB-1:0]             op_qs;
  side_t      [QB:0]                    c_side;
  lane_word_t [QB:0]                    c_rem, c_den;
  logic       [QB:0][LANES-1:0][QB-1:0] c_qs;
  logic [QB-1:0]                        q_hue, q_sat, q_lit;
  logic [QB+15:0]                       e_hue, e_sat, e_lit;

  assign adv       = !hsl_valid || hsl_ready;
  assign pix_ready = adv;

  // operand setup
  rth_prep #(.FRAC_BITS(FRAC_BITS), .QB(QB)) u_prep (
    .pix  (pix),
    .rem  (p_rem),
    .den  (p_den),
    .qs   (p_qs),
    .gray (p_gray)
  );

  // operand stage valid and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      op_side.vld <= 1'b0;
    end else if (adv) begin
      op_side.vld <= pix_valid;
    end
    if (adv) begin
      op_side.gray  <= p_gray;
      op_side.alpha <= pix.alpha_in;
      op_rem        <= p_rem;
      op_den        <= p_den;
      op_qs         <= p_qs;
    end
  end

  assign c_side[0] = op_side;
  assign c_rem[0]  = op_rem;
  assign c_den[0]  = op_den;
  assign c_qs[0]   = op_qs;

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < QB; k++) begin : g_cell
    rth_cell #(.QB(QB)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .side_in (c_side[k]),
      .rem_in  (c_rem[k]),
      .den_in  (c_den[k]),
      .qs_in   (c_qs[k]),
      .side    (c_side[k+1]),
      .rem     (c_rem[k+1]),
      .den     (c_den[k+1]),
      .qs      (c_qs[k+1])
    );
  end

  // result formatting: hue wrap, gray forcing, clip to 16 bits
  always_comb begin
    q_hue = c_qs[QB][LANE_HUE];
    q_sat = c_qs[QB][LANE_SAT];
    q_lit = c_qs[QB][LANE_LIT];
    if (c_side[QB].gray || q_hue[QB-1]) q_hue = '0;
    if (c_side[QB].gray) q_sat = '0;
    e_hue = {16'd0, q_hue};
    e_sat = {16'd0, q_sat};
    e_lit = {16'd0, q_lit};
    hsl.hue_out   = (e_hue[QB+15:16] != '0) ? 16'hFFFF : e_hue[15:0];
    hsl.sat_out   = (e_sat[QB+15:16] != '0) ? 16'hFFFF : e_sat[15:0];
    hsl.light_out = (e_lit[QB+15:16] != '0) ? 16'hFFFF : e_lit[15:0];
    hsl.alpha_out = c_side[QB].alpha;
  end

  assign hsl_valid = c_side[QB].vld;

  // a stalled result must stay put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && !hsl_ready |=> hsl_valid && $stable(hsl))
    else $error("result changed while stalled");

  // an accepted word lands in the operand stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> c_side[0].vld)
    else $error("accepted word lost");

  // saturation and lightness quotients never reach one full unit
  // (black and white divide by zero in the saturation lane; gray hides it)
  a_sat_rng: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && !c_side[QB].gray |-> !c_qs[QB][LANE_SAT][QB-1])
    else $error("saturation quotient out of range");

  a_lit_rng: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> !c_qs[QB][LANE_LIT][QB-1])
    else $error("lightness quotient out of range");

endmodule
